/* rtl/can_frame_filter_csv_logger_unit_defines.svh */
// Assertion macros used by the checker file of the CAN frame logger.
// No dependencies; expects signals named clk and rst at the point of use.
`ifndef CAN_FRAME_FILTER_CSV_LOGGER_UNIT_DEFINES_SVH
`define CAN_FRAME_FILTER_CSV_LOGGER_UNIT_DEFINES_SVH

// condition that must hold in the same cycle
`define CFCL_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition that must hold in the next cycle
`define CFCL_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cfcl_pkg.sv */
// Shared types, constants and helpers of the CAN frame CSV logger.
// No dependencies.
package cfcl_pkg;

  localparam int ID_W       = 29;
  localparam int TS_W       = 31;
  localparam int TS_DIGITS  = 10;
  localparam int HEX_DIGITS = 8;
  localparam int CFG_W      = 29;
  localparam int MODE_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int DLC_W      = 4;
  localparam int PAYLOAD_W  = 64;
  localparam int CHAR_W     = 8;
  localparam int STD_ID_W   = 11;

  localparam int MODE_LOG_STD  = 0;
  localparam int MODE_LOG_EXT  = 1;
  localparam int MODE_TS       = 2;
  localparam int MODE_START_EN = 3;
  localparam int MODE_STOP_EN  = 4;

  localparam logic [MODE_W-1:0] MODE_RESET = 5'd7;

  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_ACC_MASK    = 3'd1,
    REG_ACC_VALUE   = 3'd2,
    REG_START_MASK  = 3'd3,
    REG_START_VALUE = 3'd4,
    REG_STOP_MASK   = 3'd5,
    REG_STOP_VALUE  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic            ts_on;
    logic [TS_W-1:0] ts;
    logic [ID_W-1:0] id;
  } fmt_job_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return 8'h30 + {4'h0, d};
    end
    return 8'h37 + {4'h0, d};
  endfunction

endpackage

/* rtl/cfcl_bcd.sv */
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on cfcl_pkg.
module cfcl_bcd (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [cfcl_pkg::TS_W-1:0]            value,
  output logic [4*cfcl_pkg::TS_DIGITS-1:0]     digits,
  output logic                                 done
);
  import cfcl_pkg::*;

  localparam int CNT_W = $clog2(TS_W);
  localparam int BCD_W = 4 * TS_DIGITS;

  logic [TS_W-1:0]  bin;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] adj;
  logic [CNT_W-1:0] cnt;
  logic             run;

  always_comb begin
    for (int i = 0; i < TS_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(TS_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (run) begin
      bcd <= {adj[BCD_W-2:0], bin[TS_W-1]};
      bin <= bin << 1;
    end
  end

  assign digits = bcd;

endmodule

/* rtl/cfcl_fmt.sv */
// CSV line sequencer: one character per cycle from digit shift registers while adv is set.
// Depends on cfcl_pkg and cfcl_bcd.
module cfcl_fmt #(
  parameter  int MAXB = 8,
  localparam int BC_W = $clog2(MAXB + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  cfcl_pkg::fmt_job_t            job,
  input  logic [BC_W-1:0]               nbytes,
  input  logic [8*MAXB-1:0]             data,
  input  logic                          adv,
  output logic                          chr_valid,
  output logic [cfcl_pkg::CHAR_W-1:0]   chr,
  output logic                          chr_last,
  output logic                          busy
);
  import cfcl_pkg::*;

  localparam int CNT_W = $clog2(TS_DIGITS);
  localparam int DSR_W = 4 * TS_DIGITS;
  localparam int HSR_W = 4 * HEX_DIGITS;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CONV  = 10'b00_0000_0010,
    S_TS    = 10'b00_0000_0100,
    S_TCOM  = 10'b00_0000_1000,
    S_HEXID = 10'b00_0001_0000,
    S_BCOM  = 10'b00_0010_0000,
    S_BHI   = 10'b00_0100_0000,
    S_BLO   = 10'b00_1000_0000,
    S_CR    = 10'b01_0000_0000,
    S_LF    = 10'b10_0000_0000
  } fmt_state_t;

  fmt_state_t        state, state_next;
  logic [DSR_W-1:0]  dsr, dsr_next;
  logic [HSR_W-1:0]  hsr, hsr_next;
  logic [8*MAXB-1:0] data_sr, data_next;
  logic [BC_W-1:0]   left, left_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              started, started_next;

  logic [DSR_W-1:0]  bcd_digits;
  logic              bcd_done;
  logic [3:0]        ts_dig, id_dig;
  logic              ts_emit, id_emit;

  cfcl_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (start && job.ts_on),
    .value  (job.ts),
    .digits (bcd_digits),
    .done   (bcd_done)
  );

  assign ts_dig  = dsr[DSR_W-1 -: 4];
  assign id_dig  = hsr[HSR_W-1 -: 4];
  // leading zeros dropped, last digit always printed
  assign ts_emit = (ts_dig != 4'd0) || started || (cnt == CNT_W'(TS_DIGITS - 1));
  assign id_emit = (id_dig != 4'd0) || started || (cnt == CNT_W'(HEX_DIGITS - 1));

  always_comb begin
    state_next   = state;
    dsr_next     = dsr;
    hsr_next     = hsr;
    data_next    = data_sr;
    left_next    = left;
    cnt_next     = cnt;
    started_next = started;
    chr_valid    = 1'b0;
    chr          = CH_CR;
    chr_last     = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          hsr_next     = HSR_W'(job.id);
          data_next    = data;
          left_next    = nbytes;
          cnt_next     = '0;
          started_next = 1'b0;
          state_next   = job.ts_on ? S_CONV : S_HEXID;
        end
      end
      S_CONV: begin
        if (bcd_done) begin
          dsr_next   = bcd_digits;
          state_next = S_TS;
        end
      end
      S_TS: begin
        chr_valid = ts_emit;
        chr       = hex_char(ts_dig);
        if (!ts_emit || adv) begin
          dsr_next     = dsr << 4;
          cnt_next     = cnt + CNT_W'(1);
          started_next = started | ts_emit;
          if (cnt == CNT_W'(TS_DIGITS - 1)) begin
            cnt_next     = '0;
            started_next = 1'b0;
            state_next   = S_TCOM;
          end
        end
      end
      S_TCOM: begin
        chr_valid = 1'b1;
        chr       = CH_COMMA;
        if (adv) begin
          state_next = S_HEXID;
        end
      end
      S_HEXID: begin
        chr_valid = id_emit;
        chr       = hex_char(id_dig);
        if (!id_emit || adv) begin
          hsr_next     = hsr << 4;
          cnt_next     = cnt + CNT_W'(1);
          started_next = started | id_emit;
          if (cnt == CNT_W'(HEX_DIGITS - 1)) begin
            cnt_next     = '0;
            started_next = 1'b0;
            state_next   = (left != '0) ? S_BCOM : S_CR;
          end
        end
      end
      S_BCOM: begin
        chr_valid = 1'b1;
        chr       = CH_COMMA;
        if (adv) begin
          state_next = S_BHI;
        end
      end
      S_BHI: begin
        chr_valid = 1'b1;
        chr       = hex_char(data_sr[7:4]);
        if (adv) begin
          state_next = S_BLO;
        end
      end
      S_BLO: begin
        chr_valid = 1'b1;
        chr       = hex_char(data_sr[3:0]);
        if (adv) begin
          data_next  = data_sr >> 8;
          left_next  = left - BC_W'(1);
          state_next = (left == BC_W'(1)) ? S_CR : S_BCOM;
        end
      end
      S_CR: begin
        chr_valid = 1'b1;
        chr       = CH_CR;
        if (adv) begin
          state_next = S_LF;
        end
      end
      S_LF: begin
        chr_valid = 1'b1;
        chr       = CH_LF;
        chr_last  = 1'b1;
        if (adv) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      started <= started_next;
    end
  end

  always_ff @(posedge clk) begin
    dsr     <= dsr_next;
    hsr     <= hsr_next;
    data_sr <= data_next;
    left    <= left_next;
  end

  assign busy = (state != S_IDLE);

endmodule

/* rtl/can_frame_filter_csv_logger_unit.sv */
// Top level of the CAN frame acceptance filter and CSV line logger.
// Depends on cfcl_pkg and cfcl_fmt.
//
//  channel   handshake             words
//  in        in_valid / in_stall   action, extended, frame_id, byte_count, payload, time_stamp
//  out       out_valid / out_stall text_char, line_end, logging_on (one char per word)
//  cfg       cfg_wr_en             cfg_index, cfg_data
//
// A toggle, a dropped frame or a start frame never engages the line sequencer.
// A logged line runs the bit-serial decimal conversion first if timestamps are on,
// then gives one character per cycle out of the digit shift registers while the
// output is not stalled. Leading zeros are shifted out but not emitted.
// Reset: synchronous; not logging, mode 7, masks and values 0.
// Output stall holds the current char and pauses the sequencer.
module can_frame_filter_csv_logger_unit #(
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic                              extended,
  input  logic [cfcl_pkg::ID_W-1:0]         frame_id,
  input  logic [cfcl_pkg::DLC_W-1:0]        byte_count,
  input  logic [cfcl_pkg::PAYLOAD_W-1:0]    payload,
  input  logic [cfcl_pkg::TS_W-1:0]         time_stamp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cfcl_pkg::CHAR_W-1:0]       text_char,
  output logic                              line_end,
  output logic                              logging_on,
  input  logic                              cfg_wr_en,
  input  logic [cfcl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfcl_pkg::CFG_W-1:0]        cfg_data
);
  import cfcl_pkg::*;

  localparam int BC_W = $clog2(MAX_DATA_BYTES + 1);

  logic [MODE_W-1:0] mode_flags;
  logic [ID_W-1:0]   accept_mask, accept_value;
  logic [ID_W-1:0]   start_mask, start_value;
  logic [ID_W-1:0]   stop_mask, stop_value;
  logic              logging_active;

  logic [ID_W-1:0]   id_eff;
  logic [BC_W-1:0]   dlc_sat;
  logic              in_acc, start_hit, kind_ok, pass, stop_hit, fmt_start;
  logic              out_free;
  fmt_job_t          job;

  logic                  fmt_busy, chr_valid, chr_last;
  logic [CHAR_W-1:0]     chr;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags   <= MODE_RESET;
      accept_mask  <= '0;
      accept_value <= '0;
      start_mask   <= '0;
      start_value  <= '0;
      stop_mask    <= '0;
      stop_value   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:        mode_flags   <= cfg_data[MODE_W-1:0];
        REG_ACC_MASK:    accept_mask  <= cfg_data[ID_W-1:0];
        REG_ACC_VALUE:   accept_value <= cfg_data[ID_W-1:0];
        REG_START_MASK:  start_mask   <= cfg_data[ID_W-1:0];
        REG_START_VALUE: start_value  <= cfg_data[ID_W-1:0];
        REG_STOP_MASK:   stop_mask    <= cfg_data[ID_W-1:0];
        REG_STOP_VALUE:  stop_value   <= cfg_data[ID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = fmt_busy;
  assign in_acc   = in_valid && !in_stall;

  assign id_eff  = extended ? frame_id : ID_W'(frame_id[STD_ID_W-1:0]);
  assign dlc_sat = (byte_count > DLC_W'(MAX_DATA_BYTES)) ? BC_W'(MAX_DATA_BYTES)
                                                          : byte_count[BC_W-1:0];

  assign start_hit = mode_flags[MODE_START_EN] &&
                     ((id_eff & start_mask) == (start_value & start_mask));
  assign kind_ok   = extended ? mode_flags[MODE_LOG_EXT] : mode_flags[MODE_LOG_STD];
  assign pass      = kind_ok && ((id_eff & accept_mask) == (accept_value & accept_mask));
  assign stop_hit  = mode_flags[MODE_STOP_EN] &&
                     ((id_eff & stop_mask) == (stop_value & stop_mask));

  assign fmt_start = in_acc && !action && logging_active && pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      logging_active <= 1'b0;
    end else if (in_acc) begin
      if (action) begin
        logging_active <= !logging_active;
      end else if (!logging_active) begin
        if (start_hit) begin
          logging_active <= 1'b1;
        end
      end else if (pass && stop_hit) begin
        logging_active <= 1'b0;
      end
    end
  end

  assign job.ts_on = mode_flags[MODE_TS];
  assign job.ts    = time_stamp;
  assign job.id    = id_eff;

  cfcl_fmt #(
    .MAXB (MAX_DATA_BYTES)
  ) u_fmt (
    .clk       (clk),
    .rst       (rst),
    .start     (fmt_start),
    .job       (job),
    .nbytes    (dlc_sat),
    .data      (payload[8*MAX_DATA_BYTES-1:0]),
    .adv       (out_free),
    .chr_valid (chr_valid),
    .chr       (chr),
    .chr_last  (chr_last),
    .busy      (fmt_busy)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (chr_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // no accept while a line is in flight, so logging_active is the post-frame state
  always_ff @(posedge clk) begin
    if (chr_valid && out_free) begin
      text_char  <= chr;
      line_end   <= chr_last;
      logging_on <= logging_active;
    end
  end

endmodule

/* rtl/cfcl_checker.sv */
// Port-level checks of the CAN frame CSV logger, bound to the top level.
// Depends on cfcl_pkg and can_frame_filter_csv_logger_unit_defines.svh.
`include "can_frame_filter_csv_logger_unit_defines.svh"

module cfcl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [cfcl_pkg::CHAR_W-1:0]     text_char,
  input logic                            line_end,
  input logic                            logging_on
);
  import cfcl_pkg::*;

  `CFCL_CHECK_NOW(a_end_is_lf, out_valid && line_end, text_char == CH_LF, "line end not on LF")
  `CFCL_CHECK_NOW(a_busy_in_line, out_valid && !line_end, in_stall, "input taken mid-line")
  `CFCL_CHECK_NEXT(a_log_flag_steady, out_valid && !line_end, !out_valid || (logging_on == $past(logging_on)), "logging flag changed within a line")
  `CFCL_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(text_char) && $stable(line_end), "stalled word changed")

endmodule

bind can_frame_filter_csv_logger_unit cfcl_checker u_cfcl_checker (.*);
